// ----- rtl/core/prs_pkg.sv -----
// Shared types, constants and codes of the per-sender signal strength smoother.
package prs_pkg;

   localparam int TABLE_ENTRIES = 128;
   localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
   localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);
   localparam int ID_W          = 56;
   localparam int RSSI_W        = 8;
   localparam int FILT_W        = 16;
   localparam int SLOT_W        = 7;
   localparam int STORE_W       = 24;
   localparam int ALPHA_W       = 17;
   localparam int CSR_INDEX_W   = 8;
   localparam int DIFF_W        = STORE_W + 1;
   localparam int PROD_W        = DIFF_W + ALPHA_W + 1;
   localparam int STEP_W        = PROD_W - 16;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(1311);

   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE  = CSR_INDEX_W'(1);

   typedef struct packed {
      logic [ID_W-1:0]          sender_id;
      logic signed [RSSI_W-1:0] rssi_in;
   } req_type;

   typedef struct packed {
      logic signed [FILT_W-1:0] filtered_rssi;
      logic [SLOT_W-1:0]        slot;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic search;
      logic resolve;
      logic read_store;
      logic mul;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic search_done;
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SEARCH  = 7'b0000010,
      ST_RESOLVE = 7'b0000100,
      ST_READ    = 7'b0001000,
      ST_MUL     = 7'b0010000,
      ST_UPDATE  = 7'b0100000,
      ST_RESP    = 7'b1000000
   } state_type;

endpackage

// ----- rtl/core/per_sender_rssi_smoother.sv -----
// Top level of the per-sender signal strength smoother.
// A request beat is taken in idle; the controller then steps through search (one identifier
// read a cycle for each table entry in use, none in single mode), resolve, read, multiply,
// update and response. Only one sample is in flight; no request is taken until the
// response beat is accepted.
// Synchronous reset restores the register defaults, empties the table and marks all entries
// as awaiting their first sample; no clearing pass is needed.
module per_sender_rssi_smoother (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [prs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [prs_pkg::ALPHA_W-1:0]     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  prs_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output prs_pkg::rsp_type                rsp_data
);
   import prs_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   prs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   prs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/core/prs_ctrl.sv -----
// Controller state machine: sequences search, entry assignment, average read, multiply, update and response.
module prs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  prs_pkg::status_type status,
   output prs_pkg::cmd_type    cmd
);
   import prs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (status.search_done) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            cmd.resolve = 1'b1;
            state_in    = ST_READ;
         end
         ST_READ: begin
            cmd.read_store = 1'b1;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

// ----- rtl/core/prs_datapath.sv -----
// Datapath: registers, identifier and average memories, search compare and averaging.
module prs_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [prs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [prs_pkg::ALPHA_W-1:0]          csr_wdata,
   input  prs_pkg::req_type                     req_data,
   input  prs_pkg::cmd_type                     cmd,
   output prs_pkg::status_type                  status,
   output prs_pkg::rsp_type                     rsp_data
);
   import prs_pkg::*;

   logic [ID_W-1:0]           id_mem [TABLE_ENTRIES];
   logic signed [STORE_W-1:0] store_mem [TABLE_ENTRIES];

   logic [ALPHA_W-1:0]        alpha_ff;
   logic                      mode_ff;
   logic [COUNT_W-1:0]        used_ff, used_in;
   logic [TABLE_ENTRIES-1:0]  awaiting_ff;
   logic                      rd_valid_ff, rd_valid_in;

   logic [ID_W-1:0]           id_ff;
   logic signed [STORE_W-1:0] xq_ff;
   logic [ALPHA_W-1:0]        a_ff;
   logic [COUNT_W-1:0]        idx_ff;
   logic [COUNT_W-1:0]        n_ff;
   logic [ENTRY_W-1:0]        rd_idx_ff;
   logic [ID_W-1:0]           id_rd_ff;
   logic                      hit_ff;
   logic [ENTRY_W-1:0]        entry_ff, entry_in;
   logic signed [STORE_W-1:0] store_rd_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   rsp_type                   rsp_ff;

   logic                      new_sender;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [STEP_W-1:0]  step;
   logic signed [STEP_W-1:0]  sum;
   logic signed [STORE_W-1:0] new_val;

   assign rd_valid_in = cmd.search && (idx_ff < n_ff);
   assign status.search_done = (idx_ff >= n_ff) && !rd_valid_ff;

   assign new_sender = mode_ff && !hit_ff;
   assign used_in    = (used_ff < COUNT_W'(TABLE_ENTRIES)) ? used_ff + COUNT_W'(1) : used_ff;
   assign entry_in   = ENTRY_W'(used_in - COUNT_W'(1));

   assign diff    = DIFF_W'(xq_ff) - DIFF_W'(store_rd_ff);
   assign prod_in = diff * $signed({1'b0, a_ff});
   assign step    = prod_ff[PROD_W-1:16];
   assign sum     = STEP_W'(store_rd_ff) + step;
   assign new_val = awaiting_ff[entry_ff] ? xq_ff : sum[STORE_W-1:0];

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= ALPHA_RESET;
         mode_ff     <= 1'b1;
         used_ff     <= '0;
         awaiting_ff <= '1;
         rd_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_ALPHA: alpha_ff <= csr_wdata;
               CSR_MODE:  mode_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         rd_valid_ff <= rd_valid_in;
         if (cmd.resolve && new_sender) begin
            used_ff               <= used_in;
            awaiting_ff[entry_in] <= 1'b1;
         end
         if (cmd.update) begin
            awaiting_ff[entry_ff] <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff    <= req_data.sender_id;
         xq_ff    <= {req_data.rssi_in, 16'h0000};
         a_ff     <= (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
         idx_ff   <= '0;
         n_ff     <= mode_ff ? used_ff : '0;
         hit_ff   <= 1'b0;
         entry_ff <= '0;
      end
      if (rd_valid_in) begin
         idx_ff    <= idx_ff + COUNT_W'(1);
         rd_idx_ff <= idx_ff[ENTRY_W-1:0];
      end
      if (cmd.search && rd_valid_ff && (id_rd_ff == id_ff)) begin
         hit_ff   <= 1'b1;
         entry_ff <= rd_idx_ff;
      end
      if (cmd.resolve && new_sender) begin
         entry_ff <= entry_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.update) begin
         rsp_ff.filtered_rssi <= new_val[STORE_W-1:8];
         rsp_ff.slot          <= SLOT_W'(entry_ff);
      end
   end

   // identifier memory
   always_ff @(posedge clock) begin
      if (rd_valid_in) begin
         id_rd_ff <= id_mem[idx_ff[ENTRY_W-1:0]];
      end
      if (cmd.resolve && new_sender) begin
         id_mem[entry_in] <= id_ff;
      end
   end

   // average memory
   always_ff @(posedge clock) begin
      if (cmd.read_store) begin
         store_rd_ff <= store_mem[entry_ff];
      end
      if (cmd.update) begin
         store_mem[entry_ff] <= new_val;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the signal strength smoother: directed rows, then random phases.
module tb;
   import prs_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = CSR_INDEX_W'(255);
   localparam logic [ID_W-1:0]        ID_ONES   = '1;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 150;
   localparam int PHASE_LEN    = 204;
   localparam int NUM_PHASES   = 8;
   localparam int ID_POOL      = 150;

   typedef enum bit {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      logic [CSR_INDEX_W-1:0]   index;
      logic [ALPHA_W-1:0]       wdata;
      logic [ID_W-1:0]          id;
      logic signed [RSSI_W-1:0] rssi;
      bit                       typed;
      logic signed [FILT_W-1:0] filt;
      logic [SLOT_W-1:0]        slot;
   } plan_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [ALPHA_W-1:0]     csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;

   logic [ID_W-1:0]           known_ids [TABLE_ENTRIES];
   logic signed [STORE_W-1:0] avg_store [TABLE_ENTRIES];
   bit                        first_pending [TABLE_ENTRIES];
   int                        slots_used;
   logic [ALPHA_W-1:0]        alpha_now;
   bit                        multi_now;

   rsp_type         pending_smoothed [$];
   logic [ID_W-1:0] id_pool [ID_POOL];
   int              mismatch_cnt;
   int              samples_sent;
   int              results_seen;
   int              table_evictions;
   int              csr_writes;
   int              quiet_cycles = 0;
   bit              idle_on;
   bit              stall_on;

   plan_row_type directed_plan [22] = '{
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      56'h0,              -8'sd128, 1'b1, -16'sd32768, 7'd0},
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      ID_ONES,            8'sd127,  1'b1, 16'sd32512,  7'd1},
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      56'h0,              8'sd127,  1'b0, 16'sd0,      7'd0},
      '{ROW_CSR,    CSR_ALPHA, 17'd0,      56'h0,              8'sd0,    1'b0, 16'sd0,      7'd0},
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      56'h0,              8'sd0,    1'b0, 16'sd0,      7'd0},
      '{ROW_CSR,    CSR_ALPHA, 17'd65536,  56'h0,              8'sd0,    1'b0, 16'sd0,      7'd0},
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      ID_ONES,            -8'sd128, 1'b1, -16'sd32768, 7'd1},
      '{ROW_CSR,    CSR_ALPHA, 17'd131071, 56'h0,              8'sd0,    1'b0, 16'sd0,      7'd0},
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      56'h0,              8'sd5,    1'b1, 16'sd1280,   7'd0},
      '{ROW_CSR,    CSR_MODE,  17'd0,      56'h0,              8'sd0,    1'b0, 16'sd0,      7'd0},
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      56'h5A5A5A5AA5A5A5, -8'sd1,   1'b1, -16'sd256,   7'd0},
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      ID_ONES,            8'sd100,  1'b1, 16'sd25600,  7'd0},
      '{ROW_CSR,    CSR_MODE,  17'd1,      56'h0,              8'sd0,    1'b0, 16'sd0,      7'd0},
      '{ROW_CSR,    CSR_ALPHA, 17'd1311,   56'h0,              8'sd0,    1'b0, 16'sd0,      7'd0},
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      56'h1,              -8'sd7,   1'b1, -16'sd1792,  7'd2},
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      56'h80000000000000, 8'sd64,   1'b1, 16'sd16384,  7'd3},
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      56'h1,              8'sd127,  1'b0, 16'sd0,      7'd0},
      '{ROW_CSR,    CSR_SPARE, 17'h1FFFF,  56'h0,              8'sd0,    1'b0, 16'sd0,      7'd0},
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      56'h0,              -8'sd128, 1'b0, 16'sd0,      7'd0},
      '{ROW_CSR,    CSR_ALPHA, 17'd1,      56'h0,              8'sd0,    1'b0, 16'sd0,      7'd0},
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      56'h1,              -8'sd128, 1'b0, 16'sd0,      7'd0},
      '{ROW_SAMPLE, CSR_ALPHA, 17'd0,      ID_ONES,            8'sd127,  1'b0, 16'sd0,      7'd0}
   };

   per_sender_rssi_smoother dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rsp_type smooth_sample(req_type item);
      int                        entry;
      int                        n;
      bit                        hit;
      logic [ALPHA_W-1:0]        a;
      logic signed [STORE_W-1:0] xq;
      longint                    d;
      longint                    stepv;
      rsp_type                   r;
      entry = 0;
      a = (alpha_now > ALPHA_ONE) ? ALPHA_ONE : alpha_now;
      xq = {item.rssi_in, 16'h0000};
      if (multi_now) begin
         hit = 1'b0;
         n = slots_used;
         for (int i = 0; i < n; i++) begin
            if (known_ids[i] == item.sender_id) begin
               entry = i;
               hit = 1'b1;
            end
         end
         if (!hit) begin
            if (n < TABLE_ENTRIES) begin
               n++;
            end else begin
               table_evictions++;
            end
            slots_used = n;
            entry = n - 1;
            known_ids[entry] = item.sender_id;
            first_pending[entry] = 1'b1;
         end
      end
      if (first_pending[entry]) begin
         avg_store[entry] = xq;
         first_pending[entry] = 1'b0;
      end else begin
         d = longint'(xq) - longint'(avg_store[entry]);
         stepv = (d * longint'(a)) >>> 16;
         avg_store[entry] = STORE_W'(longint'(avg_store[entry]) + stepv);
      end
      r.filtered_rssi = avg_store[entry][STORE_W-1:8];
      r.slot = SLOT_W'(entry);
      return r;
   endfunction

   task automatic send_sample(input req_type item, input bit keep_valid, input bit typed,
                              input rsp_type typed_want);
      int      gap;
      rsp_type want;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      want = smooth_sample(item);
      pending_smoothed.push_back(typed ? typed_want : want);
      samples_sent++;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap != 0 || !keep_valid) req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [ALPHA_W-1:0] wdata,
                            input bit keep_valid);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      if (index == CSR_ALPHA) begin
         alpha_now = wdata;
      end else if (index == CSR_MODE) begin
         multi_now = wdata[0];
      end
      csr_writes++;
      if (!keep_valid) csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_smoothed.size() != 0) @(posedge clock);
   endtask

   // receive side: random stalls, compare each beat with the oldest prediction
   initial begin
      int      stall;
      rsp_type got;
      rsp_type want;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = stall_on ? $urandom_range(0, 9) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         got = rsp_data;
         results_seen++;
         if (pending_smoothed.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("unexpected beat: filtered_rssi %0d slot %0d",
                        got.filtered_rssi, got.slot);
         end else begin
            want = pending_smoothed.pop_front();
            if (got.filtered_rssi !== want.filtered_rssi || got.slot !== want.slot) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("beat %0d: filtered_rssi exp %0d got %0d, slot exp %0d got %0d",
                           results_seen, want.filtered_rssi, got.filtered_rssi,
                           want.slot, got.slot);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) === 1'b1 || (rsp_valid && rsp_ready) === 1'b1 ||
          (csr_valid && csr_ready) === 1'b1) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("per_sender_rssi_smoother test failed");
         $finish;
      end
   end

   initial begin
      req_type            item;
      rsp_type            typed_want;
      bit                 keep;
      logic [ALPHA_W-1:0] phase_alpha;
      bit                 phase_multi;
      int                 pick;
      clock = 1'b0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      alpha_now = ALPHA_RESET;
      multi_now = 1'b1;
      slots_used = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) first_pending[i] = 1'b1;
      for (int i = 0; i < ID_POOL; i++) id_pool[i] = ID_W'({$urandom(), $urandom()});
      idle_on = 1'b1;
      stall_on = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(directed_plan); i++) begin
         keep = (i + 1 < $size(directed_plan)) &&
                (directed_plan[i + 1].kind == directed_plan[i].kind);
         if (directed_plan[i].kind == ROW_CSR) begin
            wait_drained();
            write_csr(directed_plan[i].index, directed_plan[i].wdata, keep);
         end else begin
            item.sender_id = directed_plan[i].id;
            item.rssi_in = directed_plan[i].rssi;
            typed_want.filtered_rssi = directed_plan[i].filt;
            typed_want.slot = directed_plan[i].slot;
            send_sample(item, keep, directed_plan[i].typed, typed_want);
         end
      end
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         phase_multi = 1'b1;
         case (p)
            0: phase_alpha = ALPHA_RESET;
            1: phase_alpha = ALPHA_W'($urandom_range(0, 65536));
            2: phase_alpha = ALPHA_ONE;
            3: phase_alpha = '0;
            4: begin
               phase_alpha = ALPHA_W'($urandom_range(0, 65536));
               phase_multi = 1'b0;
            end
            5: phase_alpha = '1;
            6: phase_alpha = ALPHA_W'(1);
            default: phase_alpha = ALPHA_W'($urandom_range(0, 131071));
         endcase
         write_csr(CSR_ALPHA, phase_alpha, 1'b1);
         write_csr(CSR_MODE, ALPHA_W'(phase_multi), 1'b0);
         for (int k = 0; k < PHASE_LEN; k++) begin
            if (k % 25 == 0) begin
               idle_on = ($urandom_range(0, 3) != 0);
               stall_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
               item.sender_id = id_pool[$urandom_range(0, ID_POOL - 1)];
            end else if (pick < 92) begin
               item.sender_id = ID_W'({$urandom(), $urandom()});
            end else if (pick < 96) begin
               item.sender_id = pick[0] ? '0 : ID_ONES;
            end else begin
               item.sender_id = ID_W'(1) << $urandom_range(0, ID_W - 1);
            end
            if ($urandom_range(0, 9) == 0) begin
               item.rssi_in = $urandom_range(0, 1) ? 8'sh7F : 8'sh80;
            end else begin
               item.rssi_in = RSSI_W'($urandom());
            end
            keep = (k != PHASE_LEN - 1) && (k != PHASE_LEN / 2);
            send_sample(item, keep, 1'b0, '0);
            if (k == PHASE_LEN / 2) wait_drained();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d samples across %0d register writes, %0d table evictions",
               samples_sent, csr_writes, table_evictions);
      $display("checked %0d result beats, %0d mismatches", results_seen, mismatch_cnt);
      if (mismatch_cnt == 0 && pending_smoothed.size() == 0) begin
         $display("per_sender_rssi_smoother test passed");
      end else begin
         $display("per_sender_rssi_smoother test failed");
      end
      $finish;
   end

endmodule

// ----- per_sender_rssi_smoother.f -----
rtl/core/prs_pkg.sv
rtl/core/prs_ctrl.sv
rtl/core/prs_datapath.sv
rtl/core/per_sender_rssi_smoother.sv
dv/tb.sv
